// File: src/inexev_pkg.sv
// Shared types, constants and helpers of the infix expression evaluator.
package inexev_pkg;

   localparam int VALUE_W = 64;
   localparam int CH_W = 8;
   localparam int ERR_W = 3;
   localparam int OP_W = 3;
   localparam int WIDE_W = 2 * VALUE_W;

   localparam int DEF_OPERATOR_DEPTH = 16;
   localparam int DEF_OPERAND_DEPTH = 16;
   localparam int DEF_FRACTION_BITS = 16;

   localparam int DECIMAL_BASE = 10;

   localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE = 8'h39;
   localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CH_W-1:0] CH_PLUS = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CH_STAR = 8'h2A;
   localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;

   localparam logic [VALUE_W-1:0] SIGN_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [VALUE_W-1:0] POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   typedef enum logic [OP_W-1:0] {
      OPC_LPAREN = 3'd0,
      OPC_ADD    = 3'd1,
      OPC_SUB    = 3'd2,
      OPC_MUL    = 3'd3,
      OPC_DIV    = 3'd4
   } opcode_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 3'd0,
      ERR_DIV_ZERO  = 3'd1,
      ERR_STACK     = 3'd2,
      ERR_MALFORMED = 3'd3,
      ERR_OVERFLOW  = 3'd4
   } error_type;

   // Result of the multiply and divide units.
   typedef struct packed {
      logic                done;
      logic                ovf;
      logic [VALUE_W-1:0]  value;
   } arith_rsp_type;

   function automatic logic [VALUE_W-1:0] magnitude(input logic [VALUE_W-1:0] v);
      return v[VALUE_W-1] ? (VALUE_W'(0) - v) : v;
   endfunction

   // Turn a sign and a wide magnitude into a saturated signed value.
   function automatic arith_rsp_type saturate(input logic neg,
                                              input logic [WIDE_W-1:0] mag);
      arith_rsp_type r;
      r.done = 1'b1;
      if (!neg) begin
         r.ovf = (mag[WIDE_W-1:VALUE_W-1] != '0);
         r.value = r.ovf ? POS_MAX : mag[VALUE_W-1:0];
      end else begin
         r.ovf = (mag[WIDE_W-1:VALUE_W] != '0) ||
                 (mag[VALUE_W-1] && (mag[VALUE_W-2:0] != '0));
         r.value = r.ovf ? SIGN_VALUE : (VALUE_W'(0) - mag[VALUE_W-1:0]);
      end
      return r;
   endfunction

endpackage

// File: src/infix_expression_evaluator.sv
// Infix expression evaluator: sequencer over operator and operand stack memories.
// Takes one ASCII character per request and evaluates + - * / with precedence and
// parentheses; on the request marked last it emits one signed fixed-point result
// (FRACTION_BITS fraction bits) with an error code and clears for the next
// expression. Both stacks live in RAMs with registered reads; + and - are reduced
// in place, * goes to the multiplier and / to the bit-serial divider. The end of
// an expression runs its remaining reductions. No request is taken while one is
// being worked on; a finished result waits in an output register.
module infix_expression_evaluator import inexev_pkg::*; #(
   parameter int OPERATOR_DEPTH = DEF_OPERATOR_DEPTH,
   parameter int OPERAND_DEPTH = DEF_OPERAND_DEPTH,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CH_W-1:0]     req_ch,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic [ERR_W-1:0]    rsp_error
);

   localparam int OPR_AW = $clog2(OPERATOR_DEPTH);
   localparam int OPR_CW = $clog2(OPERATOR_DEPTH + 1);
   localparam int OPND_AW = $clog2(OPERAND_DEPTH);
   localparam int OPND_CW = $clog2(OPERAND_DEPTH + 1);
   localparam int ACC_W = VALUE_W - 1 - FRACTION_BITS;
   localparam int LIT_W = ACC_W + 4;

   typedef enum logic [3:0] {
      S_IDLE, S_LIT, S_CHAR, S_SCAN, S_OPD, S_LAST, S_DRAIN, S_DOP,
      S_RED, S_RA, S_RB, S_EXEC, S_WAIT, S_RET, S_FIN, S_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   logic                last_ff, last_in;
   logic                ending_ff, ending_in;
   logic [OPR_CW-1:0]   opr_cnt_ff, opr_cnt_in;
   logic [OPND_CW-1:0]  opnd_cnt_ff, opnd_cnt_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic                in_lit_ff, in_lit_in;
   error_type           err_ff, err_in;
   opcode_type          op_ff, op_in;
   logic [VALUE_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [ERR_W-1:0]    rsp_error_ff, rsp_error_in;

   logic                opnd_we;
   logic [OPND_AW-1:0]  opnd_wa, opnd_ra;
   logic [VALUE_W-1:0]  opnd_wd, opnd_rd;
   logic                opr_we;
   logic [OPR_AW-1:0]   opr_wa, opr_ra;
   logic [OP_W-1:0]     opr_wd, opr_rd;

   logic                mul_start, div_start;
   arith_rsp_type       mul_rsp, div_rsp, arith_res;

   logic                frozen;
   logic [OPR_CW-1:0]   opr_m1;
   logic [OPND_CW-1:0]  opnd_m1, opnd_m2;
   logic [CH_W-1:0]     digit_sub;
   logic [LIT_W-1:0]    lit_next;
   opcode_type          nop, top_op;
   logic                push_opnd, push_opr;
   logic [VALUE_W-1:0]  push_val;
   opcode_type          push_code;
   logic [VALUE_W-1:0]  sum, dif;

   function automatic error_type note_err(input error_type cur, input error_type e);
      if (e == ERR_OVERFLOW) begin
         return (cur == ERR_NONE) ? ERR_OVERFLOW : cur;
      end
      return (cur == ERR_NONE || cur == ERR_OVERFLOW) ? e : cur;
   endfunction

   function automatic logic [1:0] prec(input opcode_type op);
      case (op)
         OPC_ADD, OPC_SUB: return 2'd1;
         OPC_MUL, OPC_DIV: return 2'd2;
         default:          return 2'd0;
      endcase
   endfunction

   assign frozen = err_ff inside {ERR_DIV_ZERO, ERR_STACK, ERR_MALFORMED};
   assign opr_m1 = opr_cnt_ff - OPR_CW'(1);
   assign opnd_m1 = opnd_cnt_ff - OPND_CW'(1);
   assign opnd_m2 = opnd_cnt_ff - OPND_CW'(2);
   assign digit_sub = req_ch - CH_ZERO;
   assign lit_next = LIT_W'(acc_ff) * LIT_W'(DECIMAL_BASE) + LIT_W'(digit_sub[3:0]);
   assign top_op = opcode_type'(opr_rd);
   assign sum = a_ff + b_ff;
   assign dif = b_ff - a_ff;
   assign arith_res = mul_rsp.done ? mul_rsp : div_rsp;

   always_comb begin
      case (ch_ff)
         CH_PLUS:  nop = OPC_ADD;
         CH_MINUS: nop = OPC_SUB;
         CH_STAR:  nop = OPC_MUL;
         default:  nop = OPC_DIV;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ch_in = ch_ff;
      last_in = last_ff;
      ending_in = ending_ff;
      opr_cnt_in = opr_cnt_ff;
      opnd_cnt_in = opnd_cnt_ff;
      acc_in = acc_ff;
      in_lit_in = in_lit_ff;
      err_in = err_ff;
      op_in = op_ff;
      a_in = a_ff;
      b_in = b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      opnd_ra = '0;
      opr_ra = opr_m1[OPR_AW-1:0];
      push_opnd = 1'b0;
      push_val = '0;
      push_opr = 1'b0;
      push_code = OPC_LPAREN;
      mul_start = 1'b0;
      div_start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ch_in = req_ch;
               last_in = req_last;
               ending_in = 1'b0;
               if (frozen) begin
                  state_in = S_LAST;
               end else if (req_ch inside {[CH_ZERO:CH_NINE]}) begin
                  in_lit_in = 1'b1;
                  state_in = S_LAST;
                  if (lit_next > LIT_W'({ACC_W{1'b1}})) begin
                     acc_in = '1;
                     err_in = note_err(err_ff, ERR_OVERFLOW);
                  end else begin
                     acc_in = lit_next[ACC_W-1:0];
                  end
               end else begin
                  state_in = S_LIT;
               end
            end
         end
         S_LIT: begin
            if (in_lit_ff) begin
               in_lit_in = 1'b0;
               acc_in = '0;
               push_opnd = 1'b1;
               push_val = VALUE_W'(acc_ff) << FRACTION_BITS;
            end
            state_in = ending_ff ? S_DRAIN : S_CHAR;
         end
         S_CHAR: begin
            state_in = S_LAST;
            if (!frozen) begin
               case (ch_ff)
                  CH_LPAREN: begin
                     push_opr = 1'b1;
                     push_code = OPC_LPAREN;
                  end
                  CH_RPAREN, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: state_in = S_SCAN;
                  default: state_in = S_LAST;
               endcase
            end
         end
         S_SCAN: begin
            if (frozen) begin
               state_in = S_LAST;
            end else if (opr_cnt_ff == '0) begin
               state_in = S_LAST;
               if (ch_ff == CH_RPAREN) begin
                  err_in = note_err(err_ff, ERR_MALFORMED);
               end else begin
                  push_opr = 1'b1;
                  push_code = nop;
               end
            end else begin
               state_in = S_OPD;
            end
         end
         S_OPD: begin
            if (ch_ff == CH_RPAREN) begin
               opr_cnt_in = opr_m1;
               op_in = top_op;
               state_in = (top_op == OPC_LPAREN) ? S_LAST : S_RED;
            end else if (top_op != OPC_LPAREN && prec(top_op) >= prec(nop)) begin
               opr_cnt_in = opr_m1;
               op_in = top_op;
               state_in = S_RED;
            end else begin
               push_opr = 1'b1;
               push_code = nop;
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (frozen) begin
               state_in = S_FIN;
            end else begin
               ending_in = 1'b1;
               state_in = S_LIT;
            end
         end
         S_DRAIN: begin
            state_in = (frozen || opr_cnt_ff == '0) ? S_FIN : S_DOP;
         end
         S_DOP: begin
            op_in = top_op;
            opr_cnt_in = opr_m1;
            state_in = S_RED;
         end
         S_RED: begin
            if (op_ff == OPC_LPAREN || op_ff > OPC_DIV || opnd_cnt_ff < OPND_CW'(2)) begin
               err_in = note_err(err_ff, ERR_MALFORMED);
               state_in = S_RET;
            end else begin
               opnd_ra = opnd_m1[OPND_AW-1:0];
               state_in = S_RA;
            end
         end
         S_RA: begin
            a_in = opnd_rd;
            opnd_ra = opnd_m2[OPND_AW-1:0];
            state_in = S_RB;
         end
         S_RB: begin
            b_in = opnd_rd;
            opnd_cnt_in = opnd_m2;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RET;
            case (op_ff)
               OPC_ADD: begin
                  push_opnd = 1'b1;
                  push_val = sum;
                  if (a_ff[VALUE_W-1] == b_ff[VALUE_W-1] &&
                      sum[VALUE_W-1] != a_ff[VALUE_W-1]) begin
                     err_in = note_err(err_ff, ERR_OVERFLOW);
                     push_val = a_ff[VALUE_W-1] ? SIGN_VALUE : POS_MAX;
                  end
               end
               OPC_SUB: begin
                  push_opnd = 1'b1;
                  push_val = dif;
                  if (a_ff[VALUE_W-1] != b_ff[VALUE_W-1] &&
                      dif[VALUE_W-1] != b_ff[VALUE_W-1]) begin
                     err_in = note_err(err_ff, ERR_OVERFLOW);
                     push_val = b_ff[VALUE_W-1] ? SIGN_VALUE : POS_MAX;
                  end
               end
               OPC_MUL: begin
                  mul_start = 1'b1;
                  state_in = S_WAIT;
               end
               default: begin
                  if (a_ff == '0) begin
                     err_in = note_err(err_ff, ERR_DIV_ZERO);
                  end else begin
                     div_start = 1'b1;
                     state_in = S_WAIT;
                  end
               end
            endcase
         end
         S_WAIT: begin
            if (arith_res.done) begin
               push_opnd = 1'b1;
               push_val = arith_res.value;
               if (arith_res.ovf) begin
                  err_in = note_err(err_ff, ERR_OVERFLOW);
               end
               state_in = S_RET;
            end
         end
         S_RET: begin
            state_in = ending_ff ? S_DRAIN : S_SCAN;
         end
         S_FIN: begin
            if (!frozen && opnd_cnt_ff != OPND_CW'(1)) begin
               err_in = note_err(err_ff, ERR_MALFORMED);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = frozen ? '0 : opnd_rd;
               rsp_error_in = err_ff;
               opr_cnt_in = '0;
               opnd_cnt_in = '0;
               acc_in = '0;
               in_lit_in = 1'b0;
               err_in = ERR_NONE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      opnd_we = 1'b0;
      opnd_wa = opnd_cnt_in[OPND_AW-1:0];
      opnd_wd = push_val;
      if (push_opnd) begin
         if (opnd_cnt_in == OPND_CW'(OPERAND_DEPTH)) begin
            err_in = note_err(err_in, ERR_STACK);
         end else begin
            opnd_we = 1'b1;
            opnd_cnt_in = opnd_cnt_in + OPND_CW'(1);
         end
      end

      opr_we = 1'b0;
      opr_wa = opr_cnt_ff[OPR_AW-1:0];
      opr_wd = push_code;
      if (push_opr) begin
         if (opr_cnt_ff == OPR_CW'(OPERATOR_DEPTH)) begin
            err_in = note_err(err_in, ERR_STACK);
         end else begin
            opr_we = 1'b1;
            opr_cnt_in = opr_cnt_ff + OPR_CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ending_ff <= 1'b0;
         opr_cnt_ff <= '0;
         opnd_cnt_ff <= '0;
         acc_ff <= '0;
         in_lit_ff <= 1'b0;
         err_ff <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ending_ff <= ending_in;
         opr_cnt_ff <= opr_cnt_in;
         opnd_cnt_ff <= opnd_cnt_in;
         acc_ff <= acc_in;
         in_lit_ff <= in_lit_in;
         err_ff <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff <= ch_in;
      last_ff <= last_in;
      op_ff <= op_in;
      a_ff <= a_in;
      b_ff <= b_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   inexev_ram #(.WIDTH(OP_W), .DEPTH(OPERATOR_DEPTH)) u_opr_ram (
      .clock   (clock),
      .wr_en   (opr_we),
      .wr_addr (opr_wa),
      .wr_data (opr_wd),
      .rd_addr (opr_ra),
      .rd_data (opr_rd)
   );

   inexev_ram #(.WIDTH(VALUE_W), .DEPTH(OPERAND_DEPTH)) u_opnd_ram (
      .clock   (clock),
      .wr_en   (opnd_we),
      .wr_addr (opnd_wa),
      .wr_data (opnd_wd),
      .rd_addr (opnd_ra),
      .rd_data (opnd_rd)
   );

   inexev_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (a_ff),
      .b     (b_ff),
      .rsp   (mul_rsp)
   );

   inexev_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (b_ff),
      .den   (a_ff),
      .rsp   (div_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output step");

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error == ERR_DIV_ZERO || rsp_error == ERR_STACK ||
                    rsp_error == ERR_MALFORMED) |-> rsp_value == '0)
      else $error("nonzero value with a freezing error");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      opnd_cnt_ff <= OPND_CW'(OPERAND_DEPTH) && opr_cnt_ff <= OPR_CW'(OPERATOR_DEPTH))
      else $error("stack count beyond depth");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && state_in == S_IDLE |=>
         opnd_cnt_ff == '0 && opr_cnt_ff == '0 && !in_lit_ff && err_ff == ERR_NONE)
      else $error("state not cleared after result");

endmodule

// File: src/inexev_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module inexev_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/inexev_mul.sv
// Fixed-point multiplier: four 32x32 partial products, then shift and saturate.
module inexev_mul import inexev_pkg::*; #(
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [VALUE_W-1:0]  a,
   input  logic [VALUE_W-1:0]  b,
   output arith_rsp_type       rsp
);

   localparam int HALF_W = VALUE_W / 2;
   localparam logic [2:0] PP_COUNT = 3'd4;

   logic                busy_ff, busy_in;
   logic [2:0]          step_ff, step_in;
   logic                neg_ff, neg_in;
   logic [VALUE_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [VALUE_W-1:0]  pp_ff, pp_in;
   logic [WIDE_W-1:0]   acc_ff, acc_in;
   arith_rsp_type       rsp_ff, rsp_in;

   logic [2:0]          pidx;
   logic [HALF_W-1:0]   xh, yh;
   logic [WIDE_W-1:0]   pp_wide;

   assign pidx = step_ff - 3'd1;
   assign xh = step_ff[0] ? x_ff[VALUE_W-1:HALF_W] : x_ff[HALF_W-1:0];
   assign yh = step_ff[1] ? y_ff[VALUE_W-1:HALF_W] : y_ff[HALF_W-1:0];

   always_comb begin
      case ({pidx[1], pidx[0]})
         2'b00:   pp_wide = WIDE_W'(pp_ff);
         2'b11:   pp_wide = WIDE_W'(pp_ff) << VALUE_W;
         default: pp_wide = WIDE_W'(pp_ff) << HALF_W;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      neg_in = neg_ff;
      x_in = x_ff;
      y_in = y_ff;
      pp_in = pp_ff;
      acc_in = acc_ff;
      rsp_in = rsp_ff;
      rsp_in.done = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in = a[VALUE_W-1] ^ b[VALUE_W-1];
         x_in = magnitude(a);
         y_in = magnitude(b);
         acc_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         if (step_ff < PP_COUNT) begin
            pp_in = VALUE_W'(xh) * VALUE_W'(yh);
         end
         if (step_ff != '0 && step_ff <= PP_COUNT) begin
            acc_in = acc_ff + pp_wide;
         end
         if (step_ff > PP_COUNT) begin
            rsp_in = saturate(neg_ff, acc_ff >> FRACTION_BITS);
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         rsp_ff.done <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         rsp_ff.done <= rsp_in.done;
      end
      neg_ff <= neg_in;
      x_ff <= x_in;
      y_ff <= y_in;
      pp_ff <= pp_in;
      acc_ff <= acc_in;
      rsp_ff.ovf <= rsp_in.ovf;
      rsp_ff.value <= rsp_in.value;
   end

   assign rsp = rsp_ff;

endmodule

// File: src/inexev_div.sv
// Fixed-point divider: restoring division, one quotient bit per cycle.
module inexev_div import inexev_pkg::*; #(
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [VALUE_W-1:0]  num,
   input  logic [VALUE_W-1:0]  den,
   output arith_rsp_type       rsp
);

   localparam int NUM_W = VALUE_W + FRACTION_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   logic [VALUE_W-1:0]  d_ff, d_in;
   logic [VALUE_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]    n_ff, n_in;
   logic [NUM_W-1:0]    q_ff, q_in;
   arith_rsp_type       rsp_ff, rsp_in;

   logic [VALUE_W:0]    shifted, diff;
   logic                ge;

   assign shifted = {rem_ff, n_ff[NUM_W-1]};
   assign diff = shifted - {1'b0, d_ff};
   assign ge = (shifted >= {1'b0, d_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      d_in = d_ff;
      rem_in = rem_ff;
      n_in = n_ff;
      q_in = q_ff;
      rsp_in = rsp_ff;
      rsp_in.done = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(NUM_W);
         neg_in = num[VALUE_W-1] ^ den[VALUE_W-1];
         d_in = magnitude(den);
         n_in = NUM_W'(magnitude(num)) << FRACTION_BITS;
         rem_in = '0;
         q_in = '0;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = ge ? diff[VALUE_W-1:0] : shifted[VALUE_W-1:0];
            n_in = n_ff << 1;
            q_in = {q_ff[NUM_W-2:0], ge};
            cnt_in = cnt_ff - CNT_W'(1);
         end else begin
            rsp_in = saturate(neg_ff, WIDE_W'(q_ff));
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
         rsp_ff.done <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
         rsp_ff.done <= rsp_in.done;
      end
      neg_ff <= neg_in;
      d_ff <= d_in;
      rem_ff <= rem_in;
      n_ff <= n_in;
      q_ff <= q_in;
      rsp_ff.ovf <= rsp_in.ovf;
      rsp_ff.value <= rsp_in.value;
   end

   assign rsp = rsp_ff;

endmodule
